// File: hw/rtl/bpa_pkg.sv
// bpa_pkg: shared types and constants of the bitmap page allocator
// no dependencies; used by the channel interfaces, the top level and its parts

package bpa_pkg;

   localparam int OP_W     = 2;
   localparam int FIRST_W  = 16;
   localparam int COUNT_W  = 17;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 16;
   localparam int LIMIT_W  = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_ADD     = 2'd2,
      OP_RESERVE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE   = 2'd0,
      STS_NO_FIT = 2'd1,
      STS_REJECT = 2'd2,
      STS_UNUSED = 2'd3
   } status_type;

endpackage

// File: hw/rtl/bpa_req_if.sv
// bpa_req_if: request channel of the page allocator, valid/ready plus payload
// depends on bpa_pkg

interface bpa_req_if
   import bpa_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FIRST_W-1:0] base_page;
   logic [COUNT_W-1:0] page_count;

   modport source (output valid, operation, base_page, page_count, input ready);
   modport sink (input valid, operation, base_page, page_count, output ready);
endinterface

// File: hw/rtl/bpa_rsp_if.sv
// bpa_rsp_if: response channel of the page allocator, valid/ready plus payload
// depends on bpa_pkg

interface bpa_rsp_if
   import bpa_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  page_index;
   logic [COUNT_W-1:0]  free_pages;
   logic [COUNT_W-1:0]  total_pages;

   modport source (output valid, status, page_index, free_pages, total_pages, input ready);
   modport sink (input valid, status, page_index, free_pages, total_pages, output ready);
endinterface

// File: hw/rtl/bpa_mod_unit.sv
// bpa_mod_unit: iterative restoring remainder of the 16-bit hint by the page limit
// one dividend bit per cycle; depends on bpa_pkg

module bpa_mod_unit
   import bpa_pkg::*;
#(
   parameter int PW = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FIRST_W-1:0] dividend,
   input  logic [PW-1:0]      divisor,
   output logic               done,
   output logic [PW-1:0]      remainder
);

   localparam int CW = $clog2(FIRST_W + 1);

   logic [PW-1:0]      rem_ff, rem_in, shifted;
   logic [FIRST_W-1:0] sh_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   always_comb begin
      shifted = {rem_ff[PW-2:0], sh_ff[FIRST_W-1]};
      rem_in  = (shifted >= divisor) ? shifted - divisor : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            sh_ff   <= dividend;
            cnt_ff  <= CW'(FIRST_W);
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            sh_ff  <= {sh_ff[FIRST_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/bitmap_page_allocator.sv
// bitmap_page_allocator: next-fit bitmap page allocator, top level
// depends on bpa_pkg, bpa_req_if, bpa_rsp_if and bpa_mod_unit
//
// usage: one request beat on req_chan (alloc, free, add usable, reserve) gives
// exactly one response beat on rsp_chan with status, first page of an allocated
// run and the free and total page counts after the operation. the user must write
// page_limit on csr_write_en/csr_write_data only while no request is in flight;
// the block does not enforce this. the used bitmap sits in a one-port-write,
// one-port-read memory of MAX_PAGES/MAP_WORD_BITS words; one page bit is examined
// per cycle outside the word fetches. alloc first takes the remainder of the hint
// by the limit and may scan from there to the limit and then from page 0
// to the limit. reset is synchronous; afterwards a clearing pass writes all
// MAX_PAGES/MAP_WORD_BITS words, marking every page used, with req_chan.ready low.
// a response waits in an output register while rsp_chan.ready is low; the next
// request is taken meanwhile, and its response waits until the register frees.

module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int MAX_PAGES     = 65536,
   parameter int MAP_WORD_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   bpa_req_if.sink            req_chan,
   bpa_rsp_if.source          rsp_chan,
   input  logic               csr_write_en,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   localparam int BW    = $clog2(MAP_WORD_BITS);
   localparam int WORDS = MAX_PAGES / MAP_WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LW    = $clog2(MAX_PAGES) + 1;
   localparam int PW    = ((LW > COUNT_W) ? LW : COUNT_W) + 1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_CHECK, ST_LOAD, ST_FETCH, ST_BIT, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      PH_SCAN1, PH_SCAN2, PH_MARK, PH_FREE, PH_ADD, PH_RSV
   } phase_type;

   state_type                  state_ff;
   phase_type                  phase_ff;
   logic [PW-1:0]              p_ff, stop_ff, run_ff, start_ff, h_ff;
   logic [COUNT_W-1:0]         cnt_ff, free_ff, usable_ff;
   logic [FIRST_W-1:0]         hint_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   logic [MAP_WORD_BITS-1:0]   word_ff, rd_ff;
   logic [WAW-1:0]             clr_ff;
   logic                       rsp_valid_ff;
   status_type                 status_ff, rsp_status_ff;
   logic [INDEX_W-1:0]         index_ff, rsp_index_ff;
   logic [COUNT_W-1:0]         rsp_free_ff, rsp_total_ff;

   logic [MAP_WORD_BITS-1:0]   map_mem [WORDS];

   logic [PW-1:0]              lim, req_first, req_cnt, req_end, cnt_w;
   logic [PW-1:0]              p_nx, run_nx, s_cand;
   logic                       bit_used, found, is_scan, leave, req_fire;
   logic [MAP_WORD_BITS-1:0]   word_nx;
   logic                       mem_we;
   logic [WAW-1:0]             mem_waddr, mem_raddr;
   logic [MAP_WORD_BITS-1:0]   mem_wdata;
   logic                       mod_start, mod_done;
   logic [PW-1:0]              mod_rem;

   always_comb begin
      lim = ({{(PW-LIMIT_W){1'b0}}, limit_ff} > PW'(MAX_PAGES)) ?
            PW'(MAX_PAGES) : {{(PW-LIMIT_W){1'b0}}, limit_ff};
      req_first = {{(PW-FIRST_W){1'b0}}, req_chan.base_page};
      req_cnt   = {{(PW-COUNT_W){1'b0}}, req_chan.page_count};
      req_end   = req_first + req_cnt;
      cnt_w     = {{(PW-COUNT_W){1'b0}}, cnt_ff};
      req_fire  = req_chan.valid && (state_ff == ST_IDLE);
   end

   // one page bit per cycle, between word fetches
   always_comb begin
      bit_used = word_ff[p_ff[BW-1:0]];
      p_nx     = p_ff + 1'b1;
      run_nx   = bit_used ? '0 : run_ff + 1'b1;
      is_scan  = (phase_ff == PH_SCAN1) || (phase_ff == PH_SCAN2);
      found    = is_scan && (run_nx >= cnt_w);
      s_cand   = p_nx - cnt_w;
      word_nx  = word_ff;
      unique case (phase_ff)
         PH_MARK, PH_RSV:  word_nx[p_ff[BW-1:0]] = 1'b1;
         PH_FREE, PH_ADD:  word_nx[p_ff[BW-1:0]] = 1'b0;
         default:          word_nx = word_ff;
      endcase
      leave = (p_nx == stop_ff) || (p_nx[BW-1:0] == '0) || found;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = p_ff[BW+WAW-1:BW];
      mem_wdata = word_nx;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '1;
      end else if (state_ff == ST_BIT && leave) begin
         mem_we = 1'b1;
      end
      mem_raddr = p_ff[BW+WAW-1:BW];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[mem_raddr];
   end

   assign mod_start = req_fire && (op_type'(req_chan.operation) == OP_ALLOC);

   bpa_mod_unit #(.PW(PW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (hint_ff),
      .divisor   (lim),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_ff      <= '0;
         usable_ff    <= '0;
         hint_ff      <= '0;
         limit_ff     <= LIMIT_W'(65536);
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SCAN1;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == WAW'(WORDS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cnt_ff    <= req_chan.page_count;
                  index_ff  <= '0;
                  run_ff    <= '0;
                  p_ff      <= req_first;
                  unique case (op_type'(req_chan.operation))
                     OP_ALLOC: begin
                        if (req_chan.page_count == '0) begin
                           status_ff <= STS_REJECT;
                           state_ff  <= ST_RESP;
                        end else if (free_ff < req_chan.page_count || lim == '0) begin
                           status_ff <= STS_NO_FIT;
                           state_ff  <= ST_RESP;
                        end else begin
                           status_ff <= STS_DONE;
                           state_ff  <= ST_MOD;
                        end
                     end
                     OP_FREE: begin
                        phase_ff <= PH_FREE;
                        stop_ff  <= req_end;
                        if (req_first == '0 || req_cnt == '0 || req_first >= lim ||
                            req_end > lim) begin
                           status_ff <= STS_REJECT;
                           state_ff  <= ST_RESP;
                        end else begin
                           status_ff <= STS_DONE;
                           state_ff  <= ST_CHECK;
                        end
                     end
                     OP_ADD, OP_RESERVE: begin
                        phase_ff <= (op_type'(req_chan.operation) == OP_ADD) ?
                                    PH_ADD : PH_RSV;
                        stop_ff   <= (req_end > lim) ? lim : req_end;
                        status_ff <= STS_DONE;
                        state_ff  <= ST_CHECK;
                     end
                  endcase
               end
            end
            ST_MOD: begin
               if (mod_done) begin
                  h_ff     <= mod_rem;
                  p_ff     <= mod_rem;
                  stop_ff  <= lim;
                  run_ff   <= '0;
                  phase_ff <= PH_SCAN1;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (p_ff >= stop_ff) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               word_ff  <= rd_ff;
               state_ff <= ST_BIT;
            end
            ST_BIT: begin
               word_ff <= word_nx;
               unique case (phase_ff)
                  PH_FREE: begin
                     if (bit_used && free_ff != COUNT_MAX) begin
                        free_ff <= free_ff + 1'b1;
                     end
                  end
                  PH_ADD: begin
                     if (free_ff != COUNT_MAX) begin
                        free_ff <= free_ff + 1'b1;
                     end
                     if (usable_ff != COUNT_MAX) begin
                        usable_ff <= usable_ff + 1'b1;
                     end
                  end
                  PH_RSV: begin
                     if (!bit_used && free_ff != '0) begin
                        free_ff <= free_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (found) begin
                  run_ff <= run_nx;
                  if (phase_ff == PH_SCAN1 || s_cand < h_ff) begin
                     phase_ff <= PH_MARK;
                     start_ff <= s_cand;
                     p_ff     <= s_cand;
                     stop_ff  <= s_cand + cnt_w;
                     state_ff <= ST_CHECK;
                  end else begin
                     p_ff      <= p_nx;
                     status_ff <= STS_NO_FIT;
                     state_ff  <= ST_RESP;
                  end
               end else if (p_nx == stop_ff && phase_ff == PH_SCAN1) begin
                  phase_ff <= PH_SCAN2;
                  p_ff     <= '0;
                  stop_ff  <= lim;
                  run_ff   <= '0;
                  state_ff <= ST_CHECK;
               end else begin
                  p_ff   <= p_nx;
                  run_ff <= run_nx;
                  if (p_nx == stop_ff) begin
                     state_ff <= ST_RESP;
                     unique case (phase_ff)
                        PH_SCAN2: begin
                           status_ff <= STS_NO_FIT;
                        end
                        PH_MARK: begin
                           free_ff  <= free_ff - cnt_ff;
                           hint_ff  <= (p_nx == lim) ? '0 : p_nx[FIRST_W-1:0];
                           index_ff <= start_ff[INDEX_W-1:0];
                        end
                        PH_FREE: begin
                           if (stop_ff - cnt_w < {{(PW-FIRST_W){1'b0}}, hint_ff}) begin
                              hint_ff <= stop_ff[FIRST_W-1:0] - cnt_ff[FIRST_W-1:0];
                           end
                        end
                        default: begin
                        end
                     endcase
                  end else if (p_nx[BW-1:0] == '0) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_status_ff <= status_ff;
                  rsp_index_ff  <= index_ff;
                  rsp_free_ff   <= free_ff;
                  rsp_total_ff  <= usable_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.page_index  = rsp_index_ff;
   assign rsp_chan.free_pages  = rsp_free_ff;
   assign rsp_chan.total_pages = rsp_total_ff;

endmodule

// File: hw/rtl/bpa_checker.sv
// bpa_checker: port-level assertions for the bitmap page allocator
// depends on bpa_pkg; bound to bitmap_page_allocator below

module bpa_checker
   import bpa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [INDEX_W-1:0]  rsp_page_index,
   input logic [COUNT_W-1:0]  rsp_free_pages
);

   // clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready) else $error("request taken during clearing pass");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STS_UNUSED)) else $error("bad status code");

   a_index_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_DONE |-> rsp_page_index == '0)
      else $error("page index on failed beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_free_pages))
      else $error("response beat dropped or changed");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_page_index (rsp_chan.page_index),
   .rsp_free_pages (rsp_chan.free_pages)
);
